// File: rtl/vbbc_pkg.sv
// vbbc_pkg: shared widths, register indexes and controller/datapath structs
// for the vertical box blur column core. No dependencies.

package vbbc_pkg;

   localparam int PIX_W       = 8;
   localparam int CFG_W       = 13;
   localparam int WIN_W       = 6;
   localparam int HALF_W      = WIN_W - 1;
   localparam int WIN_MAX     = (1 << WIN_W) - 1;
   localparam int SUM_W       = 14;
   localparam int RING_DEPTH  = 64;
   localparam int RING_AW     = $clog2(RING_DEPTH);
   localparam int RESULT_CAP  = 32;
   localparam int CNT_W       = $clog2(RESULT_CAP + 1);
   localparam int CSR_IDX_W   = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_COLUMN_HEIGHT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE   = 1'b1;

   localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;
   localparam logic [WIN_W-1:0] WINDOW_RESET = 6'd5;

   typedef enum logic [1:0] {
      FETCH_WIN,
      FETCH_ADD,
      FETCH_SUB
   } fetch_kind_type;

   typedef struct packed {
      logic           load;
      logic           finish;
      logic           sum_clr;
      logic           fetch_en;
      fetch_kind_type fetch_kind;
      logic           div_start;
      logic           out_load;
   } cmd_type;

   typedef struct packed {
      logic emit_ok;
      logic sum_valid;
      logic k_last;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

// File: rtl/vbbc_div.sv
// vbbc_div: restoring divider, one quotient bit per cycle, for the window sum.
// Depends on vbbc_pkg.

module vbbc_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [vbbc_pkg::SUM_W-1:0] dividend,
   input  logic [vbbc_pkg::WIN_W-1:0] divisor,
   output logic                       done,
   output logic [vbbc_pkg::SUM_W-1:0] quotient
);
   import vbbc_pkg::*;

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] step_ff;
   logic [WIN_W-1:0]  rem_ff;
   logic [WIN_W-1:0]  rem_in;
   logic [SUM_W-1:0]  quo_ff;
   logic [SUM_W-1:0]  quo_in;
   logic [WIN_W:0]    trial;
   logic              qbit;

   always_comb begin
      trial = {rem_ff, quo_ff[SUM_W-1]};
      if (trial >= {1'b0, divisor}) begin
         qbit   = 1'b1;
         rem_in = WIN_W'(trial - {1'b0, divisor});
      end else begin
         qbit   = 1'b0;
         rem_in = trial[WIN_W-1:0];
      end
      quo_in = {quo_ff[SUM_W-2:0], qbit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff && step_ff == STEP_W'(1)) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= '0;
         quo_ff  <= dividend;
         step_ff <= STEP_W'(SUM_W);
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         step_ff <= step_ff - STEP_W'(1);
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/vbbc_datapath.sv
// vbbc_datapath: config registers, row history ring, running window sum,
// row counters, divider and the result register. Depends on vbbc_pkg, vbbc_div.

module vbbc_datapath #(
   parameter int MAX_WINDOW = 63,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   input  vbbc_pkg::cmd_type              cmd,
   output vbbc_pkg::status_type           status,
   input  logic [vbbc_pkg::PIX_W-1:0]     req_pixel_in,
   input  logic                           csr_write,
   input  logic [vbbc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [vbbc_pkg::CFG_W-1:0]     csr_wdata,
   input  logic                           rsp_stall,
   output logic                           rsp_valid,
   output logic [vbbc_pkg::PIX_W-1:0]     rsp_pixel_out,
   output logic                           rsp_column_done
);
   import vbbc_pkg::*;

   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int HGT_W   = $clog2(MAX_HEIGHT + 1);
   localparam int JW      = ROW_W + 2;
   localparam int WIN_CAP = (MAX_WINDOW < WIN_MAX) ? MAX_WINDOW : WIN_MAX;

   typedef enum logic [1:0] {
      SRC_RING,
      SRC_TOP,
      SRC_CUR
   } src_type;

   // configuration
   logic [CFG_W-1:0]  height_ff;
   logic [WIN_W-1:0]  wsize_ff;
   logic [HGT_W-1:0]  height_eff;
   logic [WIN_W-1:0]  div_eff;

   // column state
   logic [ROW_W-1:0]  rows_seen_ff;
   logic [ROW_W-1:0]  rows_emitted_ff;
   logic [PIX_W-1:0]  top_ff;
   logic [PIX_W-1:0]  px_ff;
   logic              last_ff;
   logic [WIN_W-1:0]  div_ff;
   logic [HALF_W-1:0] half_ff;
   logic [HALF_W-1:0] sum_half_ff;
   logic              sum_valid_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [WIN_W-1:0]  k_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              last_in;

   // history ring and fetch pipe
   logic [PIX_W-1:0]   ring_mem [RING_DEPTH];
   logic [PIX_W-1:0]   rd_ff;
   logic               fetch_vld_ff;
   logic               fetch_sub_ff;
   src_type            src_ff;
   src_type            src_in;
   logic signed [JW-1:0] fetch_row;
   logic signed [JW-1:0] row_s;
   logic signed [JW-1:0] emit_s;
   logic signed [JW-1:0] half_s;
   logic [PIX_W-1:0]   fetch_val;

   // result
   logic               rsp_valid_ff;
   logic [PIX_W-1:0]   pixel_out_ff;
   logic               done_ff;
   logic               div_done;
   logic [SUM_W-1:0]   quotient;
   logic [PIX_W-1:0]   sat_q;
   logic [ROW_W:0]     emit_need;

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= HEIGHT_RESET;
         wsize_ff  <= WINDOW_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_COLUMN_HEIGHT: height_ff <= csr_wdata;
            CSR_WINDOW_SIZE:   wsize_ff  <= csr_wdata[WIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (height_ff == '0)
         height_eff = HGT_W'(1);
      else if ({1'b0, height_ff} > (CFG_W + 1)'(MAX_HEIGHT))
         height_eff = HGT_W'(MAX_HEIGHT);
      else
         height_eff = HGT_W'(height_ff);

      if (wsize_ff == '0)
         div_eff = WIN_W'(1);
      else if (wsize_ff > WIN_W'(WIN_CAP))
         div_eff = WIN_W'(WIN_CAP);
      else
         div_eff = wsize_ff;

      last_in = ((ROW_W + 1)'(rows_seen_ff) + (ROW_W + 1)'(1)) >= (ROW_W + 1)'(height_eff);
   end

   // emit while rows_emitted <= target, target = row (flush) or row - half
   assign emit_need = (ROW_W + 1)'(rows_emitted_ff) + (last_ff ? '0 : (ROW_W + 1)'(half_ff));

   assign row_s  = JW'(rows_seen_ff);
   assign emit_s = JW'(rows_emitted_ff);
   assign half_s = JW'(half_ff);

   always_comb begin
      case (cmd.fetch_kind)
         FETCH_ADD: fetch_row = emit_s + half_s;
         FETCH_SUB: fetch_row = emit_s - JW'(1) - half_s;
         default:   fetch_row = emit_s - half_s + JW'(k_ff);
      endcase
      if (fetch_row < 0)
         src_in = SRC_TOP;
      else if (fetch_row >= row_s)
         src_in = SRC_CUR;
      else
         src_in = SRC_RING;
   end

   always_ff @(posedge clock) begin
      if (cmd.load)
         ring_mem[rows_seen_ff[RING_AW-1:0]] <= req_pixel_in;
      if (cmd.fetch_en)
         rd_ff <= ring_mem[fetch_row[RING_AW-1:0]];
   end

   always_comb begin
      case (src_ff)
         SRC_TOP: fetch_val = top_ff;
         SRC_CUR: fetch_val = px_ff;
         default: fetch_val = rd_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_seen_ff    <= '0;
         rows_emitted_ff <= '0;
         top_ff          <= '0;
         last_ff         <= 1'b0;
         sum_valid_ff    <= 1'b0;
         sum_half_ff     <= '0;
         count_ff        <= '0;
         k_ff            <= '0;
         fetch_vld_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         fetch_vld_ff <= cmd.fetch_en;

         if (cmd.load) begin
            if (rows_seen_ff == '0)
               top_ff <= req_pixel_in;
            last_ff  <= last_in;
            count_ff <= '0;
            // a sum kept for another half width cannot be slid
            if (div_eff[WIN_W-1:1] != sum_half_ff)
               sum_valid_ff <= 1'b0;
         end

         if (cmd.finish) begin
            if (last_ff) begin
               rows_seen_ff    <= '0;
               rows_emitted_ff <= '0;
               sum_valid_ff    <= 1'b0;
            end else begin
               rows_seen_ff <= rows_seen_ff + ROW_W'(1);
            end
         end

         if (cmd.sum_clr)
            k_ff <= '0;
         else if (cmd.fetch_en && cmd.fetch_kind == FETCH_WIN)
            k_ff <= k_ff + WIN_W'(1);

         if (cmd.out_load) begin
            rows_emitted_ff <= rows_emitted_ff + ROW_W'(1);
            count_ff        <= count_ff + CNT_W'(1);
            sum_valid_ff    <= 1'b1;
            sum_half_ff     <= half_ff;
            rsp_valid_ff    <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         px_ff   <= req_pixel_in;
         div_ff  <= div_eff;
         half_ff <= div_eff[WIN_W-1:1];
      end
      if (cmd.fetch_en) begin
         src_ff       <= src_in;
         fetch_sub_ff <= (cmd.fetch_kind == FETCH_SUB);
      end
      if (cmd.sum_clr)
         sum_ff <= '0;
      else if (fetch_vld_ff)
         sum_ff <= fetch_sub_ff ? sum_ff - SUM_W'(fetch_val) : sum_ff + SUM_W'(fetch_val);
      if (cmd.out_load) begin
         pixel_out_ff <= sat_q;
         done_ff      <= last_ff && ((rows_emitted_ff == rows_seen_ff) ||
                                     (count_ff == CNT_W'(RESULT_CAP - 1)));
      end
   end

   vbbc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_ff),
      .divisor  (div_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign sat_q = (|quotient[SUM_W-1:PIX_W]) ? '1 : quotient[PIX_W-1:0];

   always_comb begin
      status.emit_ok   = (emit_need <= (ROW_W + 1)'(rows_seen_ff)) &&
                         (count_ff < CNT_W'(RESULT_CAP));
      status.sum_valid = sum_valid_ff;
      status.k_last    = (k_ff == {half_ff, 1'b0});
      status.div_done  = div_done;
      status.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_out   = pixel_out_ff;
   assign rsp_column_done = done_ff;

endmodule

// File: rtl/vbbc_ctrl.sv
// vbbc_ctrl: sequencer for one request: load, per-row window sum, divide and
// result hand-off, then column bookkeeping. Depends on vbbc_pkg.

module vbbc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  vbbc_pkg::status_type status,
   output vbbc_pkg::cmd_type    cmd
);
   import vbbc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_FULL,
      ST_UPD_ADD,
      ST_UPD_SUB,
      ST_DRAIN,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_OUT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_IDLE;
      else
         state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!status.emit_ok) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else if (status.sum_valid) begin
               state_in = ST_UPD_ADD;
            end else begin
               cmd.sum_clr = 1'b1;
               state_in    = ST_FULL;
            end
         end
         ST_FULL: begin
            cmd.fetch_en   = 1'b1;
            cmd.fetch_kind = FETCH_WIN;
            if (status.k_last)
               state_in = ST_DRAIN;
         end
         ST_UPD_ADD: begin
            cmd.fetch_en   = 1'b1;
            cmd.fetch_kind = FETCH_ADD;
            state_in       = ST_UPD_SUB;
         end
         ST_UPD_SUB: begin
            cmd.fetch_en   = 1'b1;
            cmd.fetch_kind = FETCH_SUB;
            state_in       = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done)
               state_in = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_CHECK;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

// File: rtl/vertical_box_blur_column_core.sv
// Top level of the vertical box blur column core: controller plus datapath.
// Depends on vbbc_pkg, vbbc_ctrl, vbbc_datapath (which holds vbbc_div).
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_pixel_in[7:0]
//   rsp      out        rsp_valid/rsp_stall  rsp_pixel_out[7:0], rsp_column_done
//   csr      in         csr_write            csr_index[0], csr_wdata[12:0]
//
// One request at a time: bookkeeping plus, for every row it emits, a window
// sum that slides or is rebuilt from the history ring, and a divide. When the
// sum slides, the serial divider sets most of the time a row takes.
// Synchronous reset restores the register defaults and starts a new column;
// the history ring is not cleared. A stalled result is held in the output
// register while the next row is computed and the next request can be taken.

module vertical_box_blur_column_core #(
   parameter int MAX_WINDOW = 63,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [vbbc_pkg::PIX_W-1:0]     req_pixel_in,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [vbbc_pkg::PIX_W-1:0]     rsp_pixel_out,
   output logic                           rsp_column_done,
   input  logic                           csr_write,
   input  logic [vbbc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [vbbc_pkg::CFG_W-1:0]     csr_wdata
);
   import vbbc_pkg::*;

   cmd_type    cmd;
   status_type status;

   vbbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   vbbc_datapath #(
      .MAX_WINDOW (MAX_WINDOW),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_pixel_in    (req_pixel_in),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_column_done (rsp_column_done)
   );

   // a new result never overwrites one still waiting
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("result register overwritten while stalled");

   a_div_restart: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> !status.div_done)
      else $error("divider reports done right after start");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !cmd.fetch_en && !cmd.div_start && !cmd.out_load)
      else $error("datapath busy while requests are accepted");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.finish, cmd.fetch_en, cmd.div_start, cmd.out_load}))
      else $error("conflicting datapath commands");

endmodule
